>>> rtl/core/hrs_pkg.sv
`timescale 1ns / 1ps
package hrs_pkg;
	localparam logic [2:0] KIND_POLL      = 3'd0;
	localparam logic [2:0] KIND_STATE     = 3'd1;
	localparam logic [2:0] KIND_ANALOG    = 3'd2;
	localparam logic [2:0] KIND_TELEM     = 3'd3;
	localparam logic [2:0] KIND_VENDOR    = 3'd4;
	localparam logic [2:0] KIND_PHYSICAL  = 3'd5;
	localparam logic [2:0] KIND_ACTION    = 3'd6;
	localparam logic [2:0] KIND_PULSE     = 3'd7;
	localparam logic [2:0] SRC_CONSUMER   = 3'd2;
	localparam logic [2:0] SRC_NONE       = 3'd7;
	localparam logic [6:0] EPOCH_MASK     = 7'h6E;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0]  kind;
		logic        target;
		logic [15:0] usage;
		logic        pressed;
		logic        same;
		logic        same2;
		logic        wf;
		logic [31:0] epoch;
		logic [1:0]  accepts;
	} item_t;

	// result tdata: sent_source, send_ok, consumer_usage_sent, accepted, response_pending
	typedef struct packed {
		logic        pending;
		logic        acc;
		logic [15:0] use_sent;
		logic        ok;
		logic [2:0]  src;
	} res_t;
endpackage

>>> rtl/core/hrs_front.sv
`timescale 1ns / 1ps
module hrs_front import hrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);
	// two-entry queue
	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push, pop;

	always_comb begin
		in_item.kind    = s_tdata[2:0];
		in_item.target  = s_tdata[3];
		in_item.usage   = s_tdata[19:4];
		in_item.pressed = s_tdata[20];
		in_item.same    = s_tdata[21];
		in_item.same2   = s_tdata[22];
		in_item.wf      = s_tdata[23];
		in_item.epoch   = s_tdata[55:24];
		in_item.accepts = 2'b00;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("push not counted");
endmodule

>>> rtl/core/hrs_back.sv
`timescale 1ns / 1ps
module hrs_back import hrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	input  logic [1:0]  accepts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tlast
);
	logic [6:0]  valid_q, dirty_q;
	logic [15:0] held_q, phys_q, act_q, pulse_q, qpulse_q;
	logic        f_pulse_q, f_rel_q, f_queued_q;
	logic [1:0]  ccur_q, tptr_q;
	logic [31:0] last_epoch_q;
	logic        seen_q;
	logic        busy_q;
	logic        att_q;
	item_t       cur_q;
	logic        ov_q;
	res_t        out_q;
	logic        last_q;

	// combinational next state for one step
	logic [6:0]  v_n, d_n;
	logic [15:0] held_n, phys_n, act_n, pulse_n, qpulse_n, u;
	logic        fp_n, fr_n, fq_n, seen_n, att_n;
	logic [1:0]  ccur_n, tptr_n;
	logic [31:0] le_n;
	res_t        r;
	logic        do_poll, fin, done, can_step;
	item_t       it;
	logic [1:0]  idx, tidx, tp;
	logic        bit_ok, found;
	logic [6:0]  b;

	assign it = busy_q ? cur_q : q_item;
	assign can_step = !ov_q || m_tready;
	assign q_ready = !busy_q && can_step;

	always_comb begin
		v_n = valid_q; d_n = dirty_q; held_n = held_q; phys_n = phys_q;
		act_n = act_q; pulse_n = pulse_q; qpulse_n = qpulse_q;
		fp_n = f_pulse_q; fr_n = f_rel_q; fq_n = f_queued_q;
		ccur_n = ccur_q; tptr_n = tptr_q; le_n = last_epoch_q; seen_n = seen_q;
		att_n = busy_q ? att_q : 1'b0;
		r = '0; r.src = SRC_NONE; do_poll = 1'b1; fin = 1'b1; u = '0;
		found = 1'b0; b = '0; bit_ok = 1'b0; idx = '0; tidx = '0;
		tp = (tptr_q == 2'd3) ? 2'd0 : tptr_q;
		if (!busy_q) begin
			unique case (it.kind)
				KIND_POLL: ;
				KIND_STATE: begin
					b = it.target ? 7'h08 : 7'h02;
					if (!((v_n & b) != 0 && it.same)) begin v_n |= b; d_n |= b; end
				end
				KIND_ANALOG: begin
					if (!(v_n[5] && it.same)) begin v_n[5] = 1'b1; d_n[5] = 1'b1; end
					if (!(v_n[6] && it.same2)) begin v_n[6] = 1'b1; d_n[6] = 1'b1; end
				end
				KIND_TELEM: begin
					if (!it.wf) do_poll = 1'b0;
					else if (!(v_n[4] && it.same)) begin v_n[4] = 1'b1; d_n[4] = 1'b1; end
				end
				KIND_VENDOR: begin
					if (!it.wf) do_poll = 1'b0;
					else if (d_n[0]) begin do_poll = 1'b0; r.acc = it.same; end
					else begin v_n[0] = 1'b1; d_n[0] = 1'b1; r.acc = 1'b1; end
				end
				KIND_PHYSICAL, KIND_ACTION, KIND_PULSE: begin
					if (it.kind == KIND_PHYSICAL) phys_n = it.usage;
					if (it.kind == KIND_ACTION) act_n = it.pressed ? it.usage : 16'd0;
					u = (act_n != 0) ? act_n : phys_n;
					if (!(v_n[2] && (v_n[2] && held_q == u))) begin
						v_n[2] = 1'b1; d_n[2] = 1'b1;
					end
					held_n = u;
					if (it.kind == KIND_PULSE) begin
						fin = 1'b0;
						if (!fp_n && !fr_n) begin pulse_n = it.usage; fp_n = 1'b1; end
						else begin qpulse_n = it.usage; fq_n = 1'b1; end
					end
				end
				default: ;
			endcase
		end
		if (do_poll) begin
			if (!seen_n) begin le_n = it.epoch; seen_n = 1'b1; end
			else if (it.epoch != le_n) begin le_n = it.epoch; d_n |= v_n & EPOCH_MASK; end
			for (int o = 0; o < 4; o++) begin
				if (!found) begin
					idx = ccur_n + 2'(o);
					if (d_n[idx] || (idx == 2'd2 && (fp_n || fr_n))) begin
						found = 1'b1;
						bit_ok = accepts[att_n];
						if (idx == 2'd2 && fp_n) begin
							r.src = SRC_CONSUMER; r.use_sent = pulse_n; att_n = ~att_n;
							if (bit_ok) begin
								r.ok = 1'b1; fp_n = 1'b0; fr_n = 1'b1;
								d_n[2] = 1'b1; ccur_n = 2'd3;
							end
						end else if (v_n[idx] && d_n[idx]) begin
							r.src = {1'b0, idx}; att_n = ~att_n;
							if (idx == 2'd2) r.use_sent = held_n;
							if (bit_ok) begin
								r.ok = 1'b1; d_n[idx] = 1'b0;
								if (idx == 2'd2) begin
									fr_n = 1'b0;
									if (fq_n) begin pulse_n = qpulse_n; fq_n = 1'b0; fp_n = 1'b1; end
								end
								ccur_n = idx + 2'd1;
							end
						end
					end
				end
			end
			for (int o = 0; o < 3; o++) begin
				if (!found) begin
					if ((3'(tp) + 3'(o)) >= 3'd3) tidx = 2'(3'(tp) + 3'(o) - 3'd3);
					else tidx = 2'(3'(tp) + 3'(o));
					if (d_n[3'd4 + 3'(tidx)]) begin
						found = 1'b1;
						if (v_n[3'd4 + 3'(tidx)]) begin
							r.src = 3'd4 + 3'(tidx);
							bit_ok = accepts[att_n]; att_n = ~att_n;
							if (bit_ok) begin
								r.ok = 1'b1; d_n[3'd4 + 3'(tidx)] = 1'b0;
								tptr_n = (tidx == 2'd2) ? 2'd0 : tidx + 2'd1;
							end
						end
					end
				end
			end
		end
		r.pending = d_n[0];
	end

	assign done = busy_q ? 1'b1 : fin;

	always_ff @(posedge clk) begin
		if (!busy_q && q_valid && q_ready) cur_q <= q_item;
		if ((busy_q || q_valid) && can_step) begin out_q <= r; last_q <= done; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; dirty_q <= '0; held_q <= '0; phys_q <= '0; act_q <= '0;
			pulse_q <= '0; qpulse_q <= '0; f_pulse_q <= 1'b0; f_rel_q <= 1'b0;
			f_queued_q <= 1'b0; ccur_q <= '0; tptr_q <= '0; last_epoch_q <= '0;
			seen_q <= 1'b0; busy_q <= 1'b0; att_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			if ((busy_q || q_valid) && can_step) begin
				valid_q <= v_n; dirty_q <= d_n; held_q <= held_n; phys_q <= phys_n;
				act_q <= act_n; pulse_q <= pulse_n; qpulse_q <= qpulse_n;
				f_pulse_q <= fp_n; f_rel_q <= fr_n; f_queued_q <= fq_n;
				ccur_q <= ccur_n; tptr_q <= tptr_n; last_epoch_q <= le_n; seen_q <= seen_n;
				att_q <= att_n; busy_q <= !done; ov_q <= 1'b1;
			end else if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = {2'b00, out_q};
	assign m_tlast = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && can_step) |=> !busy_q)
		else $error("pulse item took more than two steps");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(out_q))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q & 7'h0F & ~7'h04) == 7'h00)
		else $error("dirty control source without valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_ready)
		else $error("accepted item mid pulse");
endmodule

>>> rtl/core/hid_report_send_scheduler.sv
`timescale 1ns / 1ps
// channel | fields (tdata low bit up)                                    | tuser
// s_axis  | kind[2:0] target usage[15:0] pressed same_content            | link_accepts[1:0]
//         | same_content_second well_formed queue_epoch[31:0]            |
// m_axis  | sent_source[2:0] send_ok consumer_usage_sent[15:0] accepted  | -, tlast = last
//         | response_pending, 2 zero pad bits                            |
// One item gives one result item; a consumer pulse gives two
// (two polls, two result items). A two-entry queue parts intake from scheduling.
// Results sit in an output register; the scheduler holds while it is full and stalled.
// Reset (arst_n low) clears all marks, pointers and flags at once.
module hid_report_send_scheduler import hrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // kind,target,usage,pressed,same,same2,wf,epoch
	input  logic [1:0]  s_axis_tuser,  // link_accepts
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // src,ok,usage_sent,accepted,pending,pad
	output logic        m_axis_tlast
);
	logic  q_valid, q_ready;
	item_t q_item;
	logic [1:0] acc_mem_q [2];
	logic wp_q, rp_q;

	// link_accepts rides alongside queue entries
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) acc_mem_q[wp_q] <= s_axis_tuser;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
		end
	end

	logic [1:0] acc_cur_q;
	always_ff @(posedge clk) begin
		if (q_valid && q_ready) acc_cur_q <= acc_mem_q[rp_q];
	end

	hrs_front u_front (
		.clk, .arst_n,
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.q_valid, .q_ready, .q_item
	);

	hrs_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.accepts(q_ready ? acc_mem_q[rp_q] : acc_cur_q),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast)
	);
endmodule

>>> verif/tb_hid_report_send_scheduler.sv
`timescale 1ns / 1ps
module tb_hid_report_send_scheduler;
	import hrs_pkg::*;

	typedef struct {
		logic [2:0]  kind;
		logic        target;
		logic [15:0] usage;
		logic        pressed;
		logic        same;
		logic        same2;
		logic        wf;
		logic [31:0] epoch;
		logic [1:0]  accepts;
	} hid_event_t;

	typedef struct {
		logic [2:0]  src;
		logic        ok;
		logic [15:0] use_sent;
		logic        acc;
		logic        pending;
		logic        last;
	} send_result_t;

	localparam logic [2:0] PF_PULSE   = 3'd1;
	localparam logic [2:0] PF_RELEASE = 3'd2;
	localparam logic [2:0] PF_QUEUED  = 3'd4;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	hid_report_send_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// scheduler state mirror
	logic [6:0]  p_valid, p_dirty;
	logic [15:0] p_held, p_phys, p_action, p_pulse, p_queued;
	logic [2:0]  p_flags;
	logic [1:0]  p_cursor, p_telem;
	logic [31:0] p_epoch;
	logic        p_epoch_seen;

	hid_event_t   pending_events[$];
	send_result_t expected_sends[$];
	int  errors = 0;
	int  accepted_cnt = 0;
	int  result_cnt = 0;
	int  sends_ok_cnt = 0;
	bit  stim_done = 0;
	bit  quiet = 0;
	bit  in_taken = 0;
	int  src_gap = 0;
	int  sink_gap = 0;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic void stage_src(int src, logic same);
		if (p_valid[src] && same) return;
		p_valid[src] = 1'b1;
		p_dirty[src] = 1'b1;
	endfunction

	function automatic void restage_consumer();
		logic [15:0] u;
		u = (p_action != 0) ? p_action : p_phys;
		stage_src(2, p_valid[2] && p_held == u);
		p_held = u;
	endfunction

	// one poll: picks the next source to send, updates marks
	function automatic void poll_once(hid_event_t ev, inout int attempt,
			output send_result_t r);
		logic [1:0] idx;
		int tidx;
		logic pend;
		logic ok;
		r.src = SRC_NONE; r.ok = 0; r.use_sent = 0; r.acc = 0; r.last = 0;
		if (!p_epoch_seen) begin
			p_epoch = ev.epoch;
			p_epoch_seen = 1'b1;
		end else if (ev.epoch != p_epoch) begin
			p_epoch = ev.epoch;
			p_dirty = p_dirty | (p_valid & EPOCH_MASK);
		end
		for (int off = 0; off < 4; off++) begin
			idx = p_cursor + 2'(off);
			pend = p_dirty[idx];
			if (idx == 2 && (p_flags & (PF_PULSE | PF_RELEASE)) != 0) pend = 1'b1;
			if (!pend) continue;
			if (idx == 2 && (p_flags & PF_PULSE) != 0) begin
				r.src = SRC_CONSUMER; r.use_sent = p_pulse;
				ok = ev.accepts[attempt & 1]; attempt++;
				if (ok) begin
					r.ok = 1;
					p_flags = (p_flags & ~PF_PULSE) | PF_RELEASE;
					p_dirty[2] = 1'b1;
					p_cursor = 2'd3;
				end
				return;
			end
			if (!(p_valid[idx] && p_dirty[idx])) return;
			r.src = {1'b0, idx};
			if (idx == 2) r.use_sent = p_held;
			ok = ev.accepts[attempt & 1]; attempt++;
			if (ok) begin
				r.ok = 1;
				p_dirty[idx] = 1'b0;
				if (idx == 2) begin
					p_flags = p_flags & ~PF_RELEASE;
					if ((p_flags & PF_QUEUED) != 0) begin
						p_pulse = p_queued;
						p_flags = (p_flags & ~PF_QUEUED) | PF_PULSE;
					end
				end
				p_cursor = idx + 2'd1;
			end
			return;
		end
		// telemetry pointer of three wraps to zero
		for (int off = 0; off < 3; off++) begin
			tidx = (int'(p_telem) + off) % 3;
			if (!p_dirty[4 + tidx]) continue;
			if (!p_valid[4 + tidx]) return;
			r.src = 3'(4 + tidx);
			ok = ev.accepts[attempt & 1]; attempt++;
			if (ok) begin
				r.ok = 1;
				p_dirty[4 + tidx] = 1'b0;
				p_telem = 2'((tidx + 1) % 3);
			end
			return;
		end
	endfunction

	function automatic void predict_sends(hid_event_t ev);
		send_result_t r;
		int attempt;
		logic acc;
		attempt = 0;
		acc = 0;
		r.src = SRC_NONE; r.ok = 0; r.use_sent = 0; r.acc = 0; r.last = 1;
		case (ev.kind)
			KIND_STATE: stage_src(ev.target ? 3 : 1, ev.same);
			KIND_ANALOG: begin
				stage_src(5, ev.same);
				stage_src(6, ev.same2);
			end
			KIND_TELEM: begin
				if (!ev.wf) begin
					r.pending = p_dirty[0];
					expected_sends.push_back(r);
					return;
				end
				stage_src(4, ev.same);
			end
			KIND_VENDOR: begin
				if (!ev.wf || p_dirty[0]) begin
					r.acc = ev.wf & ev.same;
					r.pending = p_dirty[0];
					expected_sends.push_back(r);
					return;
				end
				p_valid[0] = 1'b1; p_dirty[0] = 1'b1; acc = 1;
			end
			KIND_PHYSICAL: begin
				p_phys = ev.usage;
				restage_consumer();
			end
			KIND_ACTION: begin
				p_action = ev.pressed ? ev.usage : 16'd0;
				restage_consumer();
			end
			KIND_PULSE: begin
				restage_consumer();
				if ((p_flags & (PF_PULSE | PF_RELEASE)) == 0) begin
					p_pulse = ev.usage;
					p_flags = p_flags | PF_PULSE;
				end else begin
					p_queued = ev.usage;
					p_flags = p_flags | PF_QUEUED;
				end
				poll_once(ev, attempt, r);
				r.pending = p_dirty[0];
				expected_sends.push_back(r);
			end
			default: ;
		endcase
		poll_once(ev, attempt, r);
		r.acc = acc;
		r.pending = p_dirty[0];
		r.last = 1;
		expected_sends.push_back(r);
	endfunction

	// input handshake as seen at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// driver: next item presented at the falling edge
	always @(negedge clk) begin
		hid_event_t ev;
		if (arst_n) begin
			if (in_taken) begin
				ev = pending_events.pop_front();
				predict_sends(ev);
				accepted_cnt++;
			end
			// an item still waiting stays on the bus unchanged
			if (!s_axis_tvalid || in_taken) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 11);
					s_axis_tvalid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					ev = pending_events[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {ev.epoch, ev.wf, ev.same2, ev.same, ev.pressed,
						ev.usage, ev.target, ev.kind};
					s_axis_tuser <= ev.accepts;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(1, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		send_result_t exp_r;
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[21:0]);
			result_cnt++;
			if (expected_sends.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item src=%0d", $time, got.src);
			end else begin
				exp_r = expected_sends.pop_front();
				if (exp_r.ok) sends_ok_cnt++;
				if (got.src !== exp_r.src || got.ok !== exp_r.ok
						|| got.use_sent !== exp_r.use_sent || got.acc !== exp_r.acc
						|| got.pending !== exp_r.pending || m_axis_tlast !== exp_r.last
						|| m_axis_tdata[23:22] !== 2'b00) begin
					errors++;
					$display("%0t: mismatch exp src=%0d ok=%0d use=%h acc=%0d pend=%0d last=%0d",
						$time, exp_r.src, exp_r.ok, exp_r.use_sent, exp_r.acc,
						exp_r.pending, exp_r.last);
					$display("%0t:          got src=%0d ok=%0d use=%h acc=%0d pend=%0d last=%0d",
						$time, got.src, got.ok, got.use_sent, got.acc, got.pending,
						m_axis_tlast);
				end
			end
		end
	end

	function automatic hid_event_t rand_event(logic [2:0] kind, logic [31:0] epoch);
		hid_event_t ev;
		ev.kind = kind;
		ev.target = 1'($urandom);
		// small usage pool so coalescing and equality paths get hit
		ev.usage = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		ev.pressed = 1'($urandom);
		ev.same = 1'($urandom);
		ev.same2 = 1'($urandom);
		ev.wf = ($urandom_range(0, 4) != 0);
		ev.epoch = epoch;
		ev.accepts = ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'b11;
		return ev;
	endfunction

	function automatic void push_directed(logic [2:0] kind, logic [15:0] usage,
			logic [31:0] epoch, logic [1:0] accepts, logic flags4);
		hid_event_t ev;
		ev.kind = kind; ev.usage = usage; ev.epoch = epoch; ev.accepts = accepts;
		ev.target = flags4; ev.pressed = flags4; ev.same = flags4;
		ev.same2 = flags4; ev.wf = 1'b1;
		pending_events.push_back(ev);
	endfunction

	initial begin
		hid_event_t ev;
		logic [31:0] epoch;
		p_valid = 0; p_dirty = 0; p_held = 0; p_phys = 0; p_action = 0;
		p_pulse = 0; p_queued = 0; p_flags = 0; p_cursor = 0; p_telem = 0;
		p_epoch = 0; p_epoch_seen = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;

		// directed: first poll, every kind, extremes, refusals, pulse coalescing
		push_directed(KIND_POLL, 16'h0000, 32'hFFFF_FFFF, 2'b11, 1'b0);
		push_directed(KIND_STATE, 16'h0000, 32'hFFFF_FFFF, 2'b00, 1'b0);
		push_directed(KIND_STATE, 16'hFFFF, 32'hFFFF_FFFF, 2'b10, 1'b1);
		push_directed(KIND_ANALOG, 16'h0000, 32'hFFFF_FFFF, 2'b01, 1'b0);
		push_directed(KIND_TELEM, 16'h0000, 32'hFFFF_FFFF, 2'b11, 1'b0);
		push_directed(KIND_VENDOR, 16'h0000, 32'hFFFF_FFFF, 2'b00, 1'b0);
		push_directed(KIND_VENDOR, 16'h0000, 32'hFFFF_FFFF, 2'b00, 1'b1);
		push_directed(KIND_PHYSICAL, 16'hFFFF, 32'h0000_0000, 2'b11, 1'b0);
		push_directed(KIND_ACTION, 16'h8001, 32'h0000_0000, 2'b11, 1'b1);
		push_directed(KIND_ACTION, 16'h8001, 32'h0000_0000, 2'b11, 1'b0);
		push_directed(KIND_PULSE, 16'hFFFF, 32'h0000_0000, 2'b01, 1'b0);
		push_directed(KIND_PULSE, 16'h00E9, 32'h0000_0000, 2'b00, 1'b1);
		push_directed(KIND_PULSE, 16'h00EA, 32'h0000_0000, 2'b10, 1'b0);
		for (int i = 0; i < 6; i++)
			push_directed(KIND_POLL, 16'h0000, 32'h5555_AAAA, 2'b11, 1'b0);
		// malformed vendor report and telemetry are ignored
		ev = rand_event(KIND_VENDOR, 32'h5555_AAAA); ev.wf = 0; pending_events.push_back(ev);
		ev = rand_event(KIND_TELEM, 32'h5555_AAAA); ev.wf = 0; pending_events.push_back(ev);
		for (int i = 0; i < 4; i++)
			push_directed(KIND_POLL, 16'h0000, 32'hAAAA_5555, 2'b01, 1'b0);

		// random: mostly polls and updates, epoch changes now and then
		epoch = $urandom;
		for (int i = 0; i < 1300; i++) begin
			if ($urandom_range(0, 15) == 0)
				epoch = ($urandom_range(0, 1) == 0) ? 32'($urandom) : epoch + 1;
			if ($urandom_range(0, 2) == 0)
				ev = rand_event(KIND_POLL, epoch);
			else
				ev = rand_event(3'($urandom_range(0, 7)), epoch);
			pending_events.push_back(ev);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_events.size() < 150);
		quiet = 1;
		wait (pending_events.size() == 0 && !s_axis_tvalid);
		wait (expected_sends.size() == 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d input items, %0d result items, %0d sends taken by the link.",
			accepted_cnt, result_cnt, sends_ok_cnt);
		if (errors == 0 && expected_sends.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_sends.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
